// ===== rtl/imf_pkg.sv =====
// ----------------------------------------------------------------------------
// imf_pkg
// Shared types, codes and helpers for the image mirror/flip core.
// ----------------------------------------------------------------------------
package imf_pkg;

   typedef enum logic [1:0] {
      FMT_GRAY8       = 2'd0,
      FMT_RGB24       = 2'd1,
      FMT_RGBA32      = 2'd2,
      FMT_UNSUPPORTED = 2'd3
   } pixel_format_type;

   localparam logic [2:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_PIXEL_FORMAT = 3'd2;
   localparam logic [2:0] CSR_FLIP_ROWS    = 3'd3;
   localparam logic [2:0] CSR_FLIP_COLS    = 3'd4;

   typedef enum logic {
      ST_CLEAR = 1'b0,
      ST_RUN   = 1'b1
   } store_state_type;

   typedef struct packed {
      pixel_format_type pixel_format;
      logic             flip_rows;
      logic             flip_cols;
   } mode_cfg_type;

   typedef struct packed {
      pixel_format_type pixel_format;
      logic             line_last;
      logic             frame_last;
      logic             format_error;
   } step_meta_type;

   // Last valid index for a programmed size: zero acts as one, large values saturate.
   function automatic int unsigned clamp_last(input logic [8:0] size, input int unsigned maxv);
      int unsigned v;
      v = 32'(size);
      if (v == 0) return 0;
      if (v > maxv) return maxv - 1;
      return v - 1;
   endfunction

   function automatic logic [31:0] format_mask(input pixel_format_type fmt);
      unique case (fmt)
         FMT_GRAY8:  return 32'h0000_00FF;
         FMT_RGB24:  return 32'h00FF_FFFF;
         default:    return 32'hFFFF_FFFF;
      endcase
   endfunction

endpackage

// ===== rtl/imf_raster_ctrl.sv =====
// ----------------------------------------------------------------------------
// imf_raster_ctrl
// Raster counters and bank select; produces the store write address, the
// mirrored read address and the flags of the current transaction.
// ----------------------------------------------------------------------------
module imf_raster_ctrl
   import imf_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              step_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]                      w_last,
   input  logic [$clog2(MAX_HEIGHT)-1:0]                     h_last,
   input  mode_cfg_type                                      mode,
   output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT):0]     rd_addr,
   output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT):0]     wr_addr,
   output step_meta_type                                     meta
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);

   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   logic          bank_ff, bank_in;

   logic [XW-1:0] x, rx;
   logic [YW-1:0] y, ry;
   logic          last_col, last_row, fmt_err;

   always_comb begin
      last_col = col_ff >= w_last;
      last_row = row_ff >= h_last;
      x        = last_col ? w_last : col_ff;
      y        = last_row ? h_last : row_ff;
      fmt_err  = mode.pixel_format == FMT_UNSUPPORTED;
      rx       = (mode.flip_cols && !fmt_err) ? w_last - x : x;
      ry       = (mode.flip_rows && !fmt_err) ? h_last - y : y;
      rd_addr  = {~bank_ff, ry, rx};
      wr_addr  = {bank_ff, y, x};
      meta.pixel_format = mode.pixel_format;
      meta.line_last    = last_col;
      meta.frame_last   = last_col && last_row;
      meta.format_error = fmt_err;
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      bank_in = bank_ff;
      if (step_en) begin
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               row_in  = '0;
               bank_in = ~bank_ff;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         bank_ff <= 1'b0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         bank_ff <= bank_in;
      end
   end

endmodule

// ===== rtl/image_mirror_flip_core.sv =====
// ----------------------------------------------------------------------------
// image_mirror_flip_core
// Streaming frame mirror over a double-buffered frame store.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | req_pixel_in
//   rsp     | out       | rsp_valid/rsp_ready | rsp_pixel_out, rsp_line_last,
//           |           |                     | rsp_frame_last, rsp_format_error
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One pixel per clock sustained while rsp_ready is high and the store is not being cleared;
// each transaction passes through the store read register and then the output register
// before it appears on rsp. After reset the store is cleared one word per cycle,
// all 2**(clog2(MAX_WIDTH) + clog2(MAX_HEIGHT) + 1) words (131072 at defaults); req_ready
// stays low then. A stalled rsp holds one pixel in the read stage and one in the output
// register; outside the clear, req_ready drops only when both are full.
// ----------------------------------------------------------------------------
module image_mirror_flip_core
   import imf_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_pixel_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pixel_out,
   output logic        rsp_line_last,
   output logic        rsp_frame_last,
   output logic        rsp_format_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_data
);

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int AW    = XW + YW + 1;
   localparam int DEPTH = 1 << AW;

   // configuration
   logic [XW-1:0] w_last_ff, w_last_in;
   logic [YW-1:0] h_last_ff, h_last_in;
   mode_cfg_type  mode_ff, mode_in;

   // clearing pass
   store_state_type state_ff, state_in;
   logic [AW-1:0]   clr_addr_ff, clr_addr_in;
   logic            clear_active;

   // datapath
   logic          req_fire, out_free, s1_adv;
   logic [AW-1:0] rd_addr, wr_addr;
   step_meta_type step_meta;
   logic          s1_valid_ff, s1_valid_in;
   step_meta_type s1_meta_ff;
   logic [31:0]   rd_data_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_pixel_ff;
   step_meta_type rsp_meta_ff;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [31:0]   mem_wdata;
   logic [31:0]   frame_store_mem [DEPTH];

   assign csr_ready = 1'b1;

   always_comb begin
      w_last_in = w_last_ff;
      h_last_in = h_last_ff;
      mode_in   = mode_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  w_last_in = XW'(clamp_last(csr_data, MAX_WIDTH));
            CSR_FRAME_HEIGHT: h_last_in = YW'(clamp_last(csr_data, MAX_HEIGHT));
            CSR_PIXEL_FORMAT: mode_in.pixel_format = pixel_format_type'(csr_data[1:0]);
            CSR_FLIP_ROWS:    mode_in.flip_rows = csr_data[0];
            CSR_FLIP_COLS:    mode_in.flip_cols = csr_data[0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff <= XW'(clamp_last(9'd256, MAX_WIDTH));
         h_last_ff <= YW'(clamp_last(9'd256, MAX_HEIGHT));
         mode_ff   <= '{pixel_format: FMT_GRAY8, flip_rows: 1'b0, flip_cols: 1'b0};
      end else begin
         w_last_ff <= w_last_in;
         h_last_ff <= h_last_in;
         mode_ff   <= mode_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (&clr_addr_ff) state_in = ST_RUN;
         ST_RUN:   state_in = ST_RUN;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      unique case (state_ff)
         ST_CLEAR: clear_active = 1'b1;
         default:  clear_active = 1'b0;
      endcase
   end

   assign clr_addr_in = clear_active ? clr_addr_ff + 1'b1 : clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !clear_active && (!s1_valid_ff || out_free);
   assign req_fire  = req_valid && req_ready;

   imf_raster_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_raster (
      .clock   (clock),
      .reset   (reset),
      .step_en (req_fire),
      .w_last  (w_last_ff),
      .h_last  (h_last_ff),
      .mode    (mode_ff),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .meta    (step_meta)
   );

   always_comb begin
      mem_we    = clear_active || req_fire;
      mem_waddr = clear_active ? clr_addr_ff : wr_addr;
      mem_wdata = clear_active ? 32'd0 : req_pixel_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) frame_store_mem[mem_waddr] <= mem_wdata;
      if (req_fire) rd_data_ff <= frame_store_mem[rd_addr];
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) s1_valid_in = 1'b1;
      else if (s1_adv) s1_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold read-stage flags with the store's read register
   always_ff @(posedge clock) begin
      if (req_fire) s1_meta_ff <= step_meta;
      if (s1_adv) begin
         rsp_pixel_ff <= rd_data_ff & format_mask(s1_meta_ff.pixel_format);
         rsp_meta_ff  <= s1_meta_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_out    = rsp_pixel_ff;
   assign rsp_line_last    = rsp_meta_ff.line_last;
   assign rsp_frame_last   = rsp_meta_ff.frame_last;
   assign rsp_format_error = rsp_meta_ff.format_error;

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_active |-> !req_ready)
      else $error("transaction accepted during store clear");

   a_banks_differ: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (rd_addr[AW-1] != wr_addr[AW-1]))
      else $error("read and write hit the same bank");

   a_run_sticky: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |=> (state_ff == ST_RUN))
      else $error("store clear restarted");

   a_frame_implies_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_meta_ff.frame_last || rsp_meta_ff.line_last))
      else $error("frame_last without line_last");

   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(rd_data_ff)))
      else $error("read stage lost under stall");

endmodule
